@@ rtl/core/lcd_value_display_sequencer_assert.svh @@
// assertion macros for the lcd value display sequencer
// plain text macros, no dependencies
`ifndef LCD_VALUE_DISPLAY_SEQUENCER_ASSERT_SVH
`define LCD_VALUE_DISPLAY_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define LVDS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lvds assertion failed");

// next-cycle implication
`define LVDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lvds assertion failed");

`endif

@@ rtl/core/lvds_pkg.sv @@
// shared types and constants for the lcd value display sequencer
// no dependencies
package lvds_pkg;

  localparam int unsigned IDX_W = 6;

  // transfers per request, as last-step index
  localparam logic [IDX_W-1:0] INIT_LAST = 6'd8;
  localparam logic [IDX_W-1:0] VAL_LAST  = 6'd35;

  // lcd bytes
  localparam logic [7:0] NIB_FUNC_SET = 8'h02;
  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0E;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_LINE1    = 8'h80;
  localparam logic [7:0] CMD_LINE2    = 8'hC0;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;

  // decimal digits of one 16-bit value; thousands runs past nine
  typedef struct packed {
    logic [6:0] thou;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

endpackage

@@ rtl/core/lvds_if.sv @@
// valid/ready channel interfaces for request and strobe streams
// depends on nothing
interface lvds_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] resistance_value;
  logic [15:0] frequency_value;

  modport source(output valid, mode, resistance_value, frequency_value, input ready);
  modport sink(input valid, mode, resistance_value, frequency_value, output ready);
endinterface

interface lvds_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] shift_byte;
  logic       last;

  modport source(output valid, shift_byte, last, input ready);
  modport sink(input valid, shift_byte, last, output ready);
endinterface

@@ rtl/core/lvds_digits.sv @@
// binary to decimal digit pipeline, constant reciprocal multiplies
// depends on lvds_pkg
module lvds_digits (
  input  logic              clk,
  input  logic [15:0]       value,
  output lvds_pkg::digits_t digits
);

  logic [28:0] p1;
  logic [15:0] v1;
  logic [6:0]  q2;
  logic [15:0] v2;
  logic [10:0] r2;
  logic [6:0]  q3;
  logic [6:0]  thou;
  logic [9:0]  r3;
  logic [3:0]  hund;
  logic [9:0]  r4;
  logic [6:0]  r5;
  logic [3:0]  tens;
  logic [6:0]  r6;
  logic [3:0]  ones;

  logic [16:0] r2_full;
  logic        corr;
  logic [15:0] h_prod;
  logic [14:0] t_prod;
  logic [9:0]  r5_full;
  logic [6:0]  ones_full;

  // estimate q = v/1000 low by at most one, fix with one compare
  assign r2_full   = {1'b0, v2} - ({10'd0, q2} * 17'd1000);
  assign corr      = r2 >= 11'd1000;
  assign h_prod    = {6'd0, r3} * 16'd41;
  assign r5_full   = r4 - ({6'd0, hund} * 10'd100);
  assign t_prod    = {8'd0, r5} * 15'd205;
  assign ones_full = r6 - ({3'd0, tens} * 7'd10);

  always_ff @(posedge clk) begin
    p1   <= {13'd0, value} * 29'd4194;
    v1   <= value;
    q2   <= p1[28:22];
    v2   <= v1;
    r2   <= r2_full[10:0];
    q3   <= q2;
    thou <= q3 + {6'd0, corr};
    r3   <= corr ? 10'(r2 - 11'd1000) : r2[9:0];
    hund <= h_prod[15:12];
    r4   <= r3;
    r5   <= r5_full[6:0];
    tens <= t_prod[14:11];
    r6   <= r5;
    ones <= ones_full[3:0];
  end

  // v2 and q2 keep the value and the quotient estimate in the same stage
  assign digits.thou = thou;
  assign digits.hund = hund;
  assign digits.tens = tens;
  assign digits.ones = ones;

endmodule

@@ rtl/core/lcd_value_display_sequencer.sv @@
// Sequencer for a character LCD on a 4-bit bus behind a serial latch. One request
// gives the strobe bytes (enable high) of a full sequence, one per transfer, high
// nibble first: 9 transfers for the init sequence, 36 for the resistance and
// frequency screen. When the output side takes every transfer the block emits one
// strobe per cycle, and the next request is accepted in the same cycle that the
// final strobe of the current one is loaded into the output register. The rate is
// set by the single transfer counter. The decimal digits come from an eight-stage
// reciprocal-multiply pipeline per value that runs while the leading cursor
// command and label go out.
// depends on lvds_pkg, lvds_if, lvds_digits and the assertion header
`include "lcd_value_display_sequencer_assert.svh"

module lcd_value_display_sequencer (
  input  logic           clk,
  input  logic           rst,
  lvds_req_if.sink       req,
  lvds_rsp_if.source     rsp
);

  logic                       busy;
  logic [lvds_pkg::IDX_W-1:0] idx;
  logic                       mode_r;
  logic [15:0]                res_r;
  logic [15:0]                freq_r;
  logic                       out_valid;
  logic [7:0]                 out_byte;
  logic                       out_last;

  lvds_pkg::digits_t res_dig;
  lvds_pkg::digits_t freq_dig;

  logic step_last;
  logic emit;
  logic in_xfer;
  logic [7:0] strobe;

  lvds_digits u_res_digits (.clk(clk), .value(res_r),  .digits(res_dig));
  lvds_digits u_freq_digits(.clk(clk), .value(freq_r), .digits(freq_dig));

  function automatic logic [7:0] strobe_of(
    input logic                       mode,
    input logic [lvds_pkg::IDX_W-1:0] step,
    input lvds_pkg::digits_t          rd,
    input lvds_pkg::digits_t          fd
  );
    logic [7:0] b;
    logic       rs;
    logic [3:0] nib;
    logic [4:0] bidx;
    b    = '0;
    rs   = 1'b0;
    bidx = '0;
    if (!mode) begin
      if (step == '0) begin
        b = {lvds_pkg::NIB_FUNC_SET[3:0], lvds_pkg::NIB_FUNC_SET[3:0]};
      end else begin
        bidx = 5'(step - 6'd1) >> 1;
        case (bidx[1:0])
          2'd0:    b = lvds_pkg::CMD_FUNC_SET;
          2'd1:    b = lvds_pkg::CMD_DISP_ON;
          2'd2:    b = lvds_pkg::CMD_ENTRY;
          default: b = lvds_pkg::CMD_CLEAR;
        endcase
      end
      // odd steps carry the high nibble after the lone first nibble
      nib = step[0] ? b[7:4] : b[3:0];
    end else begin
      bidx = step[5:1];
      rs   = 1'b1;
      case (bidx)
        5'd0:    begin b = lvds_pkg::CMD_LINE2; rs = 1'b0; end
        5'd1:    b = "R";
        5'd2:    b = ":";
        5'd3:    b = lvds_pkg::ASCII_ZERO + {1'b0, rd.thou};
        5'd4:    b = {4'h3, rd.hund};
        5'd5:    b = {4'h3, rd.tens};
        5'd6:    b = {4'h3, rd.ones};
        5'd7:    b = "O";
        5'd8:    b = "h";
        5'd9:    begin b = lvds_pkg::CMD_LINE1; rs = 1'b0; end
        5'd10:   b = "F";
        5'd11:   b = ":";
        5'd12:   b = lvds_pkg::ASCII_ZERO + {1'b0, fd.thou};
        5'd13:   b = {4'h3, fd.hund};
        5'd14:   b = {4'h3, fd.tens};
        5'd15:   b = {4'h3, fd.ones};
        5'd16:   b = "H";
        default: b = "z";
      endcase
      nib = step[0] ? b[3:0] : b[7:4];
    end
    return {1'b1, rs, 2'b00, nib};
  endfunction

  assign step_last = mode_r ? (idx == lvds_pkg::VAL_LAST) : (idx == lvds_pkg::INIT_LAST);
  assign emit      = busy && (!out_valid || rsp.ready);
  assign req.ready = !busy || (emit && step_last);
  assign in_xfer   = req.valid && req.ready;
  assign strobe    = strobe_of(mode_r, idx, res_dig, freq_dig);

  assign rsp.valid      = out_valid;
  assign rsp.shift_byte = out_byte;
  assign rsp.last       = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (emit && step_last) begin
        busy <= 1'b0;
      end else if (emit) begin
        idx <= idx + 6'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r <= req.mode;
      res_r  <= req.resistance_value;
      freq_r <= req.frequency_value;
    end
    if (emit) begin
      out_byte <= strobe;
      out_last <= step_last;
    end
  end

  `LVDS_ASSERT_NEXT(a_start_at_zero, clk, rst, in_xfer, busy && idx == '0)
  `LVDS_ASSERT_NOW(a_init_bound, clk, rst, busy && !mode_r, idx <= lvds_pkg::INIT_LAST)
  `LVDS_ASSERT_NOW(a_val_bound, clk, rst, busy, idx <= lvds_pkg::VAL_LAST)
  `LVDS_ASSERT_NEXT(a_last_tag, clk, rst, emit, out_valid && out_last == $past(step_last))
  `LVDS_ASSERT_NEXT(a_done_idle, clk, rst, emit && step_last && !in_xfer, !busy)

endmodule

@@ sim/testbench.sv @@
// testbench for lcd_value_display_sequencer: init and value screens checked per strobe transfer
// depends on lvds_pkg, lvds_if and the sequencer rtl
module testbench;

  localparam logic [7:0] STROBE_EN = 8'h80;
  localparam logic [7:0] REG_SEL   = 8'h40;
  localparam logic [7:0] CH_R      = "R";
  localparam logic [7:0] CH_COLON  = ":";
  localparam logic [7:0] CH_O      = "O";
  localparam logic [7:0] CH_H_LOW  = "h";
  localparam logic [7:0] CH_F      = "F";
  localparam logic [7:0] CH_H      = "H";
  localparam logic [7:0] CH_Z      = "z";
  localparam logic       MODE_INIT   = 1'b0;
  localparam logic       MODE_VALUES = 1'b1;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [7:0] shift_byte;
    logic       last;
  } strobe_t;

  logic clk;
  logic rst;

  lvds_req_if req_ch();
  lvds_rsp_if rsp_ch();

  lcd_value_display_sequencer dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  strobe_t expected_strobes[$];
  int mismatches = 0;
  int cycle_count = 0;
  int req_gap_pct = 0;
  int rsp_stall_pct = 0;
  int hold_off_cycles = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // mostly short idles, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_nibble(input logic data, input logic [3:0] nib);
    logic [7:0] b;
    b = STROBE_EN | (data ? REG_SEL : 8'h00) | {4'h0, nib};
    expected_strobes.push_back('{shift_byte: b, last: 1'b0});
  endfunction

  function automatic void push_byte(input logic data, input logic [7:0] b);
    push_nibble(data, b[7:4]);
    push_nibble(data, b[3:0]);
  endfunction

  // thousands digit is not clamped, so values past 9999 give characters beyond '9'
  function automatic void push_decimal(input logic [15:0] v);
    int unsigned n;
    n = v;
    push_byte(1'b1, 8'(n / 1000) + lvds_pkg::ASCII_ZERO);
    push_byte(1'b1, 8'((n % 1000) / 100) + lvds_pkg::ASCII_ZERO);
    push_byte(1'b1, 8'((n % 100) / 10) + lvds_pkg::ASCII_ZERO);
    push_byte(1'b1, 8'(n % 10) + lvds_pkg::ASCII_ZERO);
  endfunction

  function automatic void predict_screen(input logic m, input logic [15:0] ohms,
                                         input logic [15:0] hertz);
    if (m == MODE_INIT) begin
      push_nibble(1'b0, lvds_pkg::NIB_FUNC_SET[3:0]);
      push_byte(1'b0, lvds_pkg::CMD_FUNC_SET);
      push_byte(1'b0, lvds_pkg::CMD_DISP_ON);
      push_byte(1'b0, lvds_pkg::CMD_ENTRY);
      push_byte(1'b0, lvds_pkg::CMD_CLEAR);
    end else begin
      push_byte(1'b0, lvds_pkg::CMD_LINE2);
      push_byte(1'b1, CH_R);
      push_byte(1'b1, CH_COLON);
      push_decimal(ohms);
      push_byte(1'b1, CH_O);
      push_byte(1'b1, CH_H_LOW);
      push_byte(1'b0, lvds_pkg::CMD_LINE1);
      push_byte(1'b1, CH_F);
      push_byte(1'b1, CH_COLON);
      push_decimal(hertz);
      push_byte(1'b1, CH_H);
      push_byte(1'b1, CH_Z);
    end
    expected_strobes[expected_strobes.size() - 1].last = 1'b1;
  endfunction

  // valid stays high from one transfer to the next unless a gap is taken
  task automatic send_request(input logic m, input logic [15:0] ohms, input logic [15:0] hertz);
    int gap;
    gap = ($urandom_range(0, 99) < req_gap_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= m;
    req_ch.resistance_value <= ohms;
    req_ch.frequency_value <= hertz;
    do @(posedge clk); while (!req_ch.ready);
    predict_screen(m, ohms, hertz);
  endtask

  function automatic logic [15:0] pick_value();
    int k;
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 9999));
      1: begin
        k = $urandom_range(1, 65);
        return 16'(k * 1000 + $urandom_range(0, 2) - 1);
      end
      2: return 16'($urandom_range(60000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : rsp_ready_driver
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        stall_left = hold_off_cycles;
        hold_off_cycles = 0;
      end else if (stall_left == 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    strobe_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_strobes.size() == 0) begin
        $error("unexpected transfer: shift_byte %h last %b", rsp_ch.shift_byte, rsp_ch.last);
        mismatches++;
      end else begin
        want = expected_strobes.pop_front();
        if (rsp_ch.shift_byte !== want.shift_byte) begin
          $error("shift_byte: expected %h actual %h", want.shift_byte, rsp_ch.shift_byte);
          mismatches++;
        end
        if (rsp_ch.last !== want.last) begin
          $error("last: expected %b actual %b", want.last, rsp_ch.last);
          mismatches++;
        end
      end
    end
  end

  task automatic apply_reset();
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  // value fields must have no effect here
  task automatic test_init_sequence();
    req_gap_pct = 20;
    rsp_stall_pct = 20;
    send_request(MODE_INIT, 16'h0000, 16'h0000);
    send_request(MODE_INIT, 16'hFFFF, 16'hFFFF);
    send_request(MODE_INIT, 16'h1234, 16'hABCD);
  endtask

  task automatic test_value_extremes();
    send_request(MODE_VALUES, 16'd0, 16'd0);
    send_request(MODE_VALUES, 16'd65535, 16'd65535);
    send_request(MODE_VALUES, 16'd9999, 16'd10000);
    send_request(MODE_VALUES, 16'd999, 16'd1000);
    send_request(MODE_VALUES, 16'hAAAA, 16'h5555);
    send_request(MODE_VALUES, 16'h5555, 16'hAAAA);
    send_request(MODE_VALUES, 16'd1, 16'd10);
    send_request(MODE_VALUES, 16'd100, 16'd12345);
  endtask

  task automatic test_back_to_back();
    req_gap_pct = 0;
    rsp_stall_pct = 0;
    send_request(MODE_VALUES, pick_value(), pick_value());
    send_request(MODE_INIT, pick_value(), pick_value());
    send_request(MODE_VALUES, pick_value(), pick_value());
    send_request(MODE_INIT, pick_value(), pick_value());
    send_request(MODE_INIT, pick_value(), pick_value());
    send_request(MODE_VALUES, pick_value(), pick_value());
  endtask

  // receiver holds off while requests keep coming, so the input has to stall
  task automatic test_output_backpressure();
    req_gap_pct = 0;
    rsp_stall_pct = 0;
    hold_off_cycles = 300;
    repeat (10) send_request($urandom_range(0, 3) != 0, pick_value(), pick_value());
  endtask

  task automatic test_random_traffic();
    int gap_pcts[4] = '{0, 30, 70, 10};
    int stall_pcts[4] = '{0, 30, 10, 70};
    for (int p = 0; p < 4; p++) begin
      req_gap_pct = gap_pcts[p];
      rsp_stall_pct = stall_pcts[p];
      repeat (96) send_request($urandom_range(0, 99) >= 20, pick_value(), pick_value());
    end
  endtask

  task automatic finish_run();
    req_ch.valid <= 1'b0;
    while (expected_strobes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  endtask

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.mode <= MODE_INIT;
    req_ch.resistance_value <= 16'h0000;
    req_ch.frequency_value <= 16'h0000;
    apply_reset();
    test_init_sequence();
    test_value_extremes();
    test_back_to_back();
    test_output_backpressure();
    test_random_traffic();
    finish_run();
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/lvds_pkg.sv
rtl/core/lvds_if.sv
rtl/core/lvds_digits.sv
rtl/core/lcd_value_display_sequencer.sv
sim/testbench.sv
